// ===== rtl/cp1251_unicode_transcoder_defines.svh =====
// Assertion macros shared by the cp1251 transcoder checkers.
// Expects signals named clk and arst_n in the scope of use.
`ifndef CP1251_UNICODE_TRANSCODER_DEFINES_SVH
`define CP1251_UNICODE_TRANSCODER_DEFINES_SVH

// Implication checked in the same cycle
`define CP_ASSERT_NOW(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("cp1251 transcoder check failed");

// Implication checked in the next cycle
`define CP_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("cp1251 transcoder check failed");

`endif

// ===== rtl/cp1251_pkg.sv =====
// Package for the cp1251 <-> Unicode transcoder: port widths, UTF-8 prefixes,
// the 128-entry cp1251 code-point table and its lookup function. No dependencies.
package cp1251_pkg;

	// Stream port widths
	localparam int S_TDATA_W = 32;  // win_byte(8), code_point(21), pad(3)
	localparam int S_TUSER_W = 1;   // mode
	localparam int M_TDATA_W = 8;   // out_byte
	localparam int CP_W      = 21;
	localparam int ROM_W     = 14;
	localparam int ROM_DEPTH = 128;

	// Item modes
	localparam logic MODE_TO_UTF8 = 1'b0;
	localparam logic MODE_TO_WIN  = 1'b1;

	// Encoding constants
	localparam logic [CP_W-1:0] CODE_BOUND = 21'd9000;
	localparam logic [7:0]      WIN_UNKNOWN = 8'h3F;
	localparam logic [2:0]      LEAD2_PFX = 3'b110;
	localparam logic [3:0]      LEAD3_PFX = 4'b1110;
	localparam logic [1:0]      CONT_PFX  = 2'b10;
	localparam logic [ROM_W-1:0] TWO_BYTE_LIMIT = 14'h0800;

	// Code point of each cp1251 byte 0x80..0xFF
	localparam logic [ROM_W-1:0] CP_ROM [ROM_DEPTH] = '{
		14'd1026, 14'd1027, 14'd8218, 14'd1107, 14'd8222, 14'd8230, 14'd8224, 14'd8225,
		14'd8364, 14'd8240, 14'd1033, 14'd8249, 14'd1034, 14'd1036, 14'd1035, 14'd1039,
		14'd1106, 14'd8216, 14'd8217, 14'd8220, 14'd8221, 14'd8226, 14'd8211, 14'd8212,
		14'd152,  14'd8482, 14'd1113, 14'd8250, 14'd1114, 14'd1116, 14'd1115, 14'd1119,
		14'd160,  14'd1038, 14'd1118, 14'd1032, 14'd164,  14'd1168, 14'd166,  14'd167,
		14'd1025, 14'd169,  14'd1028, 14'd171,  14'd172,  14'd173,  14'd174,  14'd1031,
		14'd176,  14'd177,  14'd1030, 14'd1110, 14'd1169, 14'd181,  14'd182,  14'd183,
		14'd1105, 14'd8470, 14'd1108, 14'd187,  14'd1112, 14'd1029, 14'd1109, 14'd1111,
		14'd1040, 14'd1041, 14'd1042, 14'd1043, 14'd1044, 14'd1045, 14'd1046, 14'd1047,
		14'd1048, 14'd1049, 14'd1050, 14'd1051, 14'd1052, 14'd1053, 14'd1054, 14'd1055,
		14'd1056, 14'd1057, 14'd1058, 14'd1059, 14'd1060, 14'd1061, 14'd1062, 14'd1063,
		14'd1064, 14'd1065, 14'd1066, 14'd1067, 14'd1068, 14'd1069, 14'd1070, 14'd1071,
		14'd1072, 14'd1073, 14'd1074, 14'd1075, 14'd1076, 14'd1077, 14'd1078, 14'd1079,
		14'd1080, 14'd1081, 14'd1082, 14'd1083, 14'd1084, 14'd1085, 14'd1086, 14'd1087,
		14'd1088, 14'd1089, 14'd1090, 14'd1091, 14'd1092, 14'd1093, 14'd1094, 14'd1095,
		14'd1096, 14'd1097, 14'd1098, 14'd1099, 14'd1100, 14'd1101, 14'd1102, 14'd1103
	};

	// Code point -> cp1251 byte; ASCII passes through, else parallel compare against the table,
	// the highest matching index wins; no match gives WIN_UNKNOWN
	function automatic logic [7:0] to_win(input logic [CP_W-1:0] cp);
		logic [7:0] res;
		res = WIN_UNKNOWN;
		if (cp < CODE_BOUND) begin
			if (cp[CP_W-1:7] == '0) begin
				res = {1'b0, cp[6:0]};
			end else begin
				for (int i = 0; i < ROM_DEPTH; i++) begin
					if (CP_ROM[i] == cp[ROM_W-1:0]) begin
						res = {1'b1, 7'(i)};
					end
				end
			end
		end
		return res;
	endfunction

endpackage

// ===== rtl/cp1251_unicode_transcoder.sv =====
// Top level of the cp1251 <-> Unicode transcoder (single module).
// Depends on cp1251_pkg.
//
// Each input beat carries a mode in tuser: mode 0 turns the cp1251 byte in
// tdata[7:0] into one to three UTF-8 bytes, mode 1 turns the code point in
// tdata[28:8] into one cp1251 byte ('?' when it has no cp1251 form). Output
// beats carry one byte each, with tlast on the final byte of an input item.
// The input beat is registered, converted by combinational table logic, and
// loaded into a three-byte result register that drains one byte per clock
// while the output is ready. An item has 1, 2 or 3 bytes, and a new input
// beat is taken in the cycle the last byte of the previous item leaves, so
// with the output never stalled the block sustains one output byte per
// clock; the output port width sets that figure.
module cp1251_unicode_transcoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [7:0] win_byte, [28:8] code_point, [31:29] zero
	input  logic [cp1251_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [0] mode
	input  logic [cp1251_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] out_byte
	output logic [cp1251_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);
	import cp1251_pkg::*;

	// Input stage
	logic              valid_s1;
	logic              mode_s1;
	logic [7:0]        win_byte_s1;
	logic [CP_W-1:0]   code_point_s1;

	// Result register: bytes drain from index 0, rem_q = bytes left
	logic [7:0]        byte_q [3];
	logic [1:0]        rem_q;

	// Conversion results
	logic [7:0]        new_byte [3];
	logic [1:0]        new_cnt;
	logic [ROM_W-1:0]  code;

	logic              load_res;
	logic              emit;

	assign emit     = (rem_q != 2'd0) && m_axis_tready;
	assign load_res = valid_s1 && ((rem_q == 2'd0) || ((rem_q == 2'd1) && m_axis_tready));
	assign s_axis_tready = !valid_s1 || load_res;

	assign m_axis_tvalid = (rem_q != 2'd0);
	assign m_axis_tdata  = byte_q[0];
	assign m_axis_tlast  = (rem_q == 2'd1);

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1       <= s_axis_tuser[0];
			win_byte_s1   <= s_axis_tdata[7:0];
			code_point_s1 <= s_axis_tdata[CP_W+7:8];
		end
	end

	// Table lookup and UTF-8 / cp1251 encoding
	always_comb begin
		code        = CP_ROM[win_byte_s1[6:0]];
		new_byte[0] = win_byte_s1;
		new_byte[1] = {CONT_PFX, code[5:0]};
		new_byte[2] = {CONT_PFX, code[5:0]};
		new_cnt     = 2'd1;
		if (mode_s1 == MODE_TO_WIN) begin
			new_byte[0] = to_win(code_point_s1);
		end else if (win_byte_s1[7]) begin
			if (code < TWO_BYTE_LIMIT) begin
				new_byte[0] = {LEAD2_PFX, code[10:6]};
				new_cnt     = 2'd2;
			end else begin
				new_byte[0] = {LEAD3_PFX, 2'b00, code[13:12]};
				new_byte[1] = {CONT_PFX, code[11:6]};
				new_cnt     = 2'd3;
			end
		end
	end

	// Result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load_res) begin
			rem_q <= new_cnt;
		end else if (emit) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	// Result bytes: load, or shift down one byte per output beat
	always_ff @(posedge clk) begin
		if (load_res) begin
			byte_q[0] <= new_byte[0];
			byte_q[1] <= new_byte[1];
			byte_q[2] <= new_byte[2];
		end else if (emit) begin
			byte_q[0] <= byte_q[1];
			byte_q[1] <= byte_q[2];
		end
	end

endmodule

// ===== rtl/cp1251_unicode_transcoder_checker.sv =====
// Port-level checker for the cp1251 transcoder, bound to the top level.
// Depends on cp1251_pkg and cp1251_unicode_transcoder_defines.svh.
`include "cp1251_unicode_transcoder_defines.svh"

module cp1251_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	// [7:0] out_byte
	input logic [cp1251_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tlast
);
	import cp1251_pkg::*;

	// A stalled output beat holds
	`CP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// Only the tail of a multi-byte sequence can be a non-last beat's follower; non-last beats are never ASCII
	`CP_ASSERT_NOW(a_nonlast_high, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[7])

	// A two-byte lead is followed at once by its last continuation byte
	`CP_ASSERT_NEXT(a_lead2_tail, m_axis_tvalid && m_axis_tready && !m_axis_tlast && (m_axis_tdata[7:5] == LEAD2_PFX), m_axis_tvalid && m_axis_tlast && (m_axis_tdata[7:6] == CONT_PFX))

	// A three-byte lead is followed at once by a non-last continuation byte
	`CP_ASSERT_NEXT(a_lead3_mid, m_axis_tvalid && m_axis_tready && !m_axis_tlast && (m_axis_tdata[7:4] == LEAD3_PFX), m_axis_tvalid && !m_axis_tlast && (m_axis_tdata[7:6] == CONT_PFX))

endmodule

bind cp1251_unicode_transcoder cp1251_checker u_cp1251_checker (.*);
